// ===== rtl/damped_rotary_spring_step_macros.svh =====
// Assertion macros shared by the rotary spring block
`ifndef DAMPED_ROTARY_SPRING_STEP_MACROS_SVH
`define DAMPED_ROTARY_SPRING_STEP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define DRS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRS_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/drs_pkg.sv =====
// Shared types and constants of the rotary spring block
package drs_pkg;

	localparam int MUL_W = 32;
	localparam int DIV_W = 64;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_REST_ANGLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd2;

	localparam int EXP_TERMS = 24;
	localparam int EXP_SQUARES = 5;
	localparam logic [63:0] Q62_ONE = 64'd1 << 62;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== rtl/drs_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product
module drs_mul (
	input  logic clk,
	input  logic [drs_pkg::MUL_W-1:0] a,
	input  logic [drs_pkg::MUL_W-1:0] b,
	output logic [2*drs_pkg::MUL_W-1:0] p
);

	logic [2*drs_pkg::MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ===== rtl/drs_div.sv =====
// Restoring divider, one quotient bit per cycle
module drs_div (
	input  logic clk,
	input  logic arst_n,
	input  drs_pkg::div_req_t req,
	output drs_pkg::div_rsp_t rsp
);

	localparam int W = drs_pkg::DIV_W;

	logic [drs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic done_q;
	logic [W-1:0] n_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] den_q;
	logic [W:0] trial;
	logic [W:0] diff;
	logic ge;

	assign trial = {rem_q, n_q[W-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q <= drs_pkg::DIV_CNT_W'(W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			done_q <= (cnt_q == drs_pkg::DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// n_q shifts the dividend out and the quotient in
	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			n_q <= {n_q[W-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
		end
	end

	assign rsp.busy = (cnt_q != '0);
	assign rsp.done = done_q;
	assign rsp.quot = n_q;

endmodule

// ===== rtl/damped_rotary_spring_step.sv =====
// One item at a time; the input stalls until an item is done. The pace is set by
// the one-bit-per-cycle divider (up to 25 divisions per damping item) and the
// 32x32 multiplier taking four passes per 64-bit product.
// Reset clears the state, the configuration registers, the effective moment, the saved timestep and out_valid.
// The result register lets the next item be accepted while a result waits.
module damped_rotary_spring_step #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [drs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic kind,
	input  logic signed [31:0] angle_a,
	input  logic signed [31:0] angle_b,
	input  logic signed [31:0] ang_vel_a,
	input  logic signed [31:0] ang_vel_b,
	input  logic [30:0] inv_moment_a,
	input  logic [30:0] inv_moment_b,
	input  logic [30:0] timestep,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] new_ang_vel_a,
	output logic signed [31:0] new_ang_vel_b,
	output logic signed [31:0] damped_rel_vel,
	output logic zero_mass_flag
);

	`include "damped_rotary_spring_step_macros.svh"

	localparam int SAT_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam int WIDE = 66;
	localparam logic signed [WIDE-1:0] VMAX_W = (66'sd1 <<< (SAT_BITS - 1)) - 66'sd1;
	localparam logic signed [WIDE-1:0] VMIN_W = -VMAX_W - 66'sd1;
	localparam logic [63:0] VMAX_U = 64'(VMAX_W);
	localparam logic signed [SAT_BITS-1:0] VMAX_S = SAT_BITS'(VMAX_W);
	localparam logic signed [SAT_BITS-1:0] VMIN_S = SAT_BITS'(VMIN_W);
	localparam logic [63:0] X_LIMIT = 64'd32 << FRAC_BITS;
	localparam logic signed [32:0] ONE_Q = 33'sd1 <<< FRAC_BITS;
	localparam int KW = $clog2(drs_pkg::EXP_TERMS + 1);
	localparam int SQW = $clog2(drs_pkg::EXP_SQUARES + 1);

	typedef enum logic [25:0] {
		ST_IDLE   = 26'd1 << 0,
		ST_P_SUM  = 26'd1 << 1,
		ST_P_DIVW = 26'd1 << 2,
		ST_P_M1   = 26'd1 << 3,
		ST_P_M1R  = 26'd1 << 4,
		ST_P_M2   = 26'd1 << 5,
		ST_P_M2R  = 26'd1 << 6,
		ST_D_T    = 26'd1 << 7,
		ST_D_TR   = 26'd1 << 8,
		ST_D_DIVW = 26'd1 << 9,
		ST_E_INIT = 26'd1 << 10,
		ST_E_MUL  = 26'd1 << 11,
		ST_E_ACC  = 26'd1 << 12,
		ST_E_DIVW = 26'd1 << 13,
		ST_E_RND  = 26'd1 << 14,
		ST_D_WD   = 26'd1 << 15,
		ST_D_WDR  = 26'd1 << 16,
		ST_D_J    = 26'd1 << 17,
		ST_D_JR   = 26'd1 << 18,
		ST_T_MA   = 26'd1 << 19,
		ST_T_MAR  = 26'd1 << 20,
		ST_T_MB   = 26'd1 << 21,
		ST_T_MBR  = 26'd1 << 22,
		ST_DONE   = 26'd1 << 23,
		ST_SPARE0 = 26'd1 << 24,
		ST_SPARE1 = 26'd1 << 25
	} state_t;

	function automatic logic signed [SAT_BITS-1:0] sat_w(input logic signed [WIDE-1:0] v);
		logic signed [SAT_BITS-1:0] r;
		if (v > VMAX_W)
			r = VMAX_S;
		else if (v < VMIN_W)
			r = VMIN_S;
		else
			r = SAT_BITS'(v);
		return r;
	endfunction

	// rounded fixed-point product from a magnitude product and its sign
	function automatic logic signed [SAT_BITS-1:0] mulq_fin(input logic [63:0] p,
			input logic neg);
		logic [63:0] r;
		logic signed [SAT_BITS-1:0] res;
		r = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (neg) begin
			if (r > VMAX_U + 64'd1)
				r = VMAX_U + 64'd1;
			res = SAT_BITS'(64'd0 - r);
		end else begin
			if (r > VMAX_U)
				r = VMAX_U;
			res = SAT_BITS'(r);
		end
		return res;
	endfunction

	function automatic logic [31:0] mag(input logic signed [32:0] v);
		logic signed [32:0] n;
		n = -v;
		return v[32] ? 32'(n) : 32'(v);
	endfunction

	function automatic logic signed [SAT_BITS-1:0] clamp_q(input logic [63:0] q);
		return (q > VMAX_U) ? VMAX_S : SAT_BITS'(q);
	endfunction

	state_t state_q, state_d;

	logic signed [31:0] rest_q;
	logic [30:0] stiff_q;
	logic [30:0] damp_q;
	logic signed [SAT_BITS-1:0] eff_q;
	logic signed [SAT_BITS-1:0] ts_q;
	logic out_valid_q;
	logic [KW-1:0] k_q;
	logic [1:0] pp_q;
	logic sq_mode_q;
	logic [SQW-1:0] sqc_q;

	logic signed [SAT_BITS-1:0] va_q, vb_q, ia_q, ib_q, diff_q, w_q;
	logic signed [SAT_BITS-1:0] j_q, wd_q, rel_q, na_q, nb_q, x_q;
	logic flag_q;
	logic neg_q;
	logic signed [32:0] coef_q;
	logic [63:0] y_q, term_q, sum_q;
	logic [127:0] acc_q;
	logic signed [31:0] out_a_q, out_b_q, out_rel_q;
	logic out_flag_q;

	logic in_accept;
	logic load_out;
	logic sum_zero;
	logic x_big;
	logic signed [SAT_BITS-1:0] va_in, vb_in, aa_in, ab_in, ia_in, ib_in, rest_s;
	logic signed [SAT_BITS-1:0] stiff_s, damp_s, mq_res;
	logic signed [32:0] op_a, op_b;
	logic neg_d;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [63:0] sel_a, sel_b;
	logic [127:0] acc_next;
	logic [63:0] shr_res;
	logic [63:0] e_val;
	logic [63:0] sum_ab;
	drs_pkg::div_req_t div_req;
	drs_pkg::div_rsp_t div_rsp;

	drs_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.p(mul_p)
	);

	drs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign va_in = sat_w(WIDE'(ang_vel_a));
	assign vb_in = sat_w(WIDE'(ang_vel_b));
	assign aa_in = sat_w(WIDE'(angle_a));
	assign ab_in = sat_w(WIDE'(angle_b));
	assign ia_in = sat_w(WIDE'(inv_moment_a));
	assign ib_in = sat_w(WIDE'(inv_moment_b));
	assign rest_s = sat_w(WIDE'(rest_q));
	assign stiff_s = sat_w(WIDE'(stiff_q));
	assign damp_s = sat_w(WIDE'(damp_q));

	assign sum_ab = 64'(unsigned'(ia_q)) + 64'(unsigned'(ib_q));
	assign sum_zero = (sum_ab == 64'd0);
	assign x_big = (64'(unsigned'(x_q)) >= X_LIMIT);
	assign mq_res = mulq_fin(mul_p, neg_q);

	// 64x64 product built from four 32x32 passes
	always_comb begin
		case (pp_q)
			2'd0: acc_next = acc_q + 128'(mul_p);
			2'd3: acc_next = acc_q + (128'(mul_p) << 64);
			default: acc_next = acc_q + (128'(mul_p) << 32);
		endcase
	end
	assign shr_res = acc_next[125:62];
	assign e_val = (sum_q + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_P_M1: begin op_a = 33'(diff_q); op_b = 33'(stiff_s); end
			ST_P_M2: begin op_a = 33'(j_q); op_b = 33'(ts_q); end
			ST_D_T: begin op_a = 33'(damp_s); op_b = 33'(ts_q); end
			ST_D_WD: begin op_a = 33'(w_q); op_b = coef_q; end
			ST_D_J: begin op_a = 33'(wd_q); op_b = 33'(eff_q); end
			ST_T_MA: begin op_a = 33'(j_q); op_b = 33'(ia_q); end
			ST_T_MB: begin op_a = 33'(j_q); op_b = 33'(ib_q); end
			default: begin op_a = '0; op_b = '0; end
		endcase
		neg_d = op_a[32] ^ op_b[32];
		sel_a = sq_mode_q ? sum_q : term_q;
		sel_b = sq_mode_q ? sum_q : y_q;
		if (state_q == ST_E_MUL) begin
			mul_a = pp_q[1] ? sel_a[63:32] : sel_a[31:0];
			mul_b = pp_q[0] ? sel_b[63:32] : sel_b[31:0];
		end else begin
			mul_a = mag(op_a);
			mul_b = mag(op_b);
		end
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num = '0;
		div_req.den = '0;
		case (state_q)
			ST_P_SUM: begin
				div_req.start = !sum_zero;
				div_req.num = (64'd1 << (2 * FRAC_BITS)) + (sum_ab >> 1);
				div_req.den = sum_ab;
			end
			ST_D_TR: begin
				div_req.start = (eff_q > 0);
				div_req.num = (64'(unsigned'(mq_res)) << FRAC_BITS)
					+ (64'(unsigned'(eff_q)) >> 1);
				div_req.den = 64'(unsigned'(eff_q));
			end
			ST_E_ACC: begin
				div_req.start = (pp_q == 2'd3) && !sq_mode_q;
				div_req.num = shr_res;
				div_req.den = 64'(k_q);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_accept) state_d = kind ? ST_D_T : ST_P_SUM;
			ST_P_SUM: state_d = sum_zero ? ST_P_M1 : ST_P_DIVW;
			ST_P_DIVW: if (div_rsp.done) state_d = ST_P_M1;
			ST_P_M1: state_d = ST_P_M1R;
			ST_P_M1R: state_d = ST_P_M2;
			ST_P_M2: state_d = ST_P_M2R;
			ST_P_M2R: state_d = ST_T_MA;
			ST_D_T: state_d = ST_D_TR;
			ST_D_TR: state_d = (eff_q > 0) ? ST_D_DIVW : ST_E_INIT;
			ST_D_DIVW: if (div_rsp.done) state_d = ST_E_INIT;
			ST_E_INIT: state_d = x_big ? ST_D_WD : ST_E_MUL;
			ST_E_MUL: state_d = ST_E_ACC;
			ST_E_ACC: begin
				if (pp_q != 2'd3)
					state_d = ST_E_MUL;
				else if (!sq_mode_q)
					state_d = ST_E_DIVW;
				else if (sqc_q == SQW'(drs_pkg::EXP_SQUARES - 1))
					state_d = ST_E_RND;
				else
					state_d = ST_E_MUL;
			end
			ST_E_DIVW: if (div_rsp.done) state_d = ST_E_MUL;
			ST_E_RND: state_d = ST_D_WD;
			ST_D_WD: state_d = ST_D_WDR;
			ST_D_WDR: state_d = ST_D_J;
			ST_D_J: state_d = ST_D_JR;
			ST_D_JR: state_d = ST_T_MA;
			ST_T_MA: state_d = ST_T_MAR;
			ST_T_MAR: state_d = ST_T_MB;
			ST_T_MB: state_d = ST_T_MBR;
			ST_T_MBR: state_d = ST_DONE;
			ST_DONE: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rest_q <= '0;
			stiff_q <= '0;
			damp_q <= '0;
			eff_q <= '0;
			ts_q <= '0;
			out_valid_q <= 1'b0;
			k_q <= '0;
			pp_q <= '0;
			sq_mode_q <= 1'b0;
			sqc_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					drs_pkg::REG_REST_ANGLE: rest_q <= cfg_data;
					drs_pkg::REG_STIFFNESS: stiff_q <= cfg_data[30:0];
					drs_pkg::REG_DAMPING: damp_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			out_valid_q <= load_out || (out_valid_q && out_stall);
			if (in_accept && !kind)
				ts_q <= sat_w(WIDE'(timestep));
			if (state_q == ST_P_SUM && sum_zero)
				eff_q <= VMAX_S;
			if (state_q == ST_P_DIVW && div_rsp.done)
				eff_q <= clamp_q(div_rsp.quot);
			case (state_q)
				ST_E_INIT: begin
					k_q <= KW'(1);
					pp_q <= '0;
					sq_mode_q <= 1'b0;
					sqc_q <= '0;
				end
				ST_E_ACC: begin
					pp_q <= pp_q + 2'd1;
					if (pp_q == 2'd3 && sq_mode_q)
						sqc_q <= sqc_q + 1'b1;
				end
				ST_E_DIVW: begin
					if (div_rsp.done) begin
						k_q <= k_q + 1'b1;
						if (k_q == KW'(drs_pkg::EXP_TERMS))
							sq_mode_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		neg_q <= neg_d;
		if (in_accept) begin
			va_q <= va_in;
			vb_q <= vb_in;
			ia_q <= ia_in;
			ib_q <= ib_in;
			diff_q <= sat_w(WIDE'(aa_in) - WIDE'(ab_in) - WIDE'(rest_s));
			w_q <= sat_w(WIDE'(va_in) - WIDE'(vb_in));
			rel_q <= '0;
			flag_q <= 1'b0;
		end
		case (state_q)
			ST_P_SUM: if (sum_zero) flag_q <= 1'b1;
			ST_P_M1R, ST_P_M2R, ST_D_JR: j_q <= mq_res;
			ST_D_TR: if (!(eff_q > 0)) x_q <= VMAX_S;
			ST_D_DIVW: if (div_rsp.done) x_q <= clamp_q(div_rsp.quot);
			ST_E_INIT: begin
				y_q <= 64'(unsigned'(x_q)) << (57 - FRAC_BITS);
				term_q <= drs_pkg::Q62_ONE;
				sum_q <= drs_pkg::Q62_ONE;
				acc_q <= '0;
				coef_q <= ONE_Q;
			end
			ST_E_ACC: begin
				acc_q <= (pp_q == 2'd3) ? 128'd0 : acc_next;
				if (pp_q == 2'd3 && sq_mode_q)
					sum_q <= shr_res;
			end
			ST_E_DIVW: begin
				if (div_rsp.done) begin
					term_q <= div_rsp.quot;
					// odd terms of the series subtract
					sum_q <= k_q[0] ? sum_q - div_rsp.quot : sum_q + div_rsp.quot;
				end
			end
			ST_E_RND: coef_q <= ONE_Q - 33'(e_val);
			ST_D_WDR: begin
				wd_q <= mq_res;
				rel_q <= sat_w(WIDE'(w_q) - WIDE'(mq_res));
			end
			ST_T_MAR: na_q <= sat_w(WIDE'(va_q) - WIDE'(mq_res));
			ST_T_MBR: nb_q <= sat_w(WIDE'(vb_q) + WIDE'(mq_res));
			default: ;
		endcase
		if (load_out) begin
			out_a_q <= 32'(na_q);
			out_b_q <= 32'(nb_q);
			out_rel_q <= 32'(rel_q);
			out_flag_q <= flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign new_ang_vel_a = out_a_q;
	assign new_ang_vel_b = out_b_q;
	assign damped_rel_vel = out_rel_q;
	assign zero_mass_flag = out_flag_q;

	`DRS_ASSERT_NXT(a_busy_after_accept, in_accept, in_stall, "accepted item did not block input")
	`DRS_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`DRS_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "result without finished item")
	`DRS_ASSERT_IMP(a_term_range, state_q == ST_E_DIVW, (k_q >= KW'(1)) && (k_q <= KW'(drs_pkg::EXP_TERMS)), "series index out of range")

endmodule
